// ===== hdl/l4pbom_pkg.sv =====
// Shared types, constants and widths for the layer-4 port bucket occupancy maps.
// Used by the controller, the datapath and the top level; depends on nothing.
package l4pbom_pkg;

  localparam int PORT_W          = 16;
  localparam int BUCKET_SIZE     = 256;
  localparam int BITS_PER_WORD   = 32;
  localparam int MAP_WORDS       = 8;
  localparam int NUM_MAPS        = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int BUCKETS_PER_MAP = MAP_WORDS * BITS_PER_WORD;
  localparam int BUCKET_SHIFT    = $clog2(BUCKET_SIZE);
  localparam int BUCKET_W        = $clog2(BUCKETS_PER_MAP);
  localparam int BIT_SEL_W       = $clog2(BITS_PER_WORD);
  localparam int WORD_IDX_W      = $clog2(MAP_WORDS);
  localparam int MAP_W           = $clog2(NUM_MAPS);
  localparam int PTR_W           = MAP_W + WORD_IDX_W;
  localparam int NUM_WORDS       = NUM_MAPS * MAP_WORDS;

  // Source maps (TCP, UDP) share one count bank and destination maps the other.
  localparam int BANK_DEPTH      = 2 * BUCKETS_PER_MAP;
  localparam int BANK_AW         = $clog2(BANK_DEPTH);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_SYNC = 2'd2,
    CMD_ENC  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SYNC_WALK,
    ST_SUMMARY,
    ST_ENC_WALK
  } state_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_NEXT_MAP
  } ptr_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SYNC_WORD,
    EMIT_SUMMARY,
    EMIT_ENC_WORD
  } emit_t;

  typedef struct packed {
    logic    clear_step;
    logic    load_item;
    logic    upd_write;
    ptr_op_t ptr_op;
    emit_t   emit;
  } ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic map_flagged;
    logic map_last;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/l4pbom_ctrl.sv =====
// Sequencing state machine for the occupancy maps: clearing pass, count updates,
// sync and encode walks. Depends on l4pbom_pkg for its state, command and status types.
module l4pbom_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          cmd,
  output logic                in_ready,
  input  l4pbom_pkg::stat_t   st,
  output l4pbom_pkg::ctrl_t   ctl
);

  l4pbom_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= l4pbom_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      l4pbom_pkg::ST_CLEAR: begin
        if (st.clear_done) state_next = l4pbom_pkg::ST_IDLE;
      end
      l4pbom_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (l4pbom_pkg::cmd_t'(cmd))
            l4pbom_pkg::CMD_ADD, l4pbom_pkg::CMD_DEL: state_next = l4pbom_pkg::ST_UPDATE;
            l4pbom_pkg::CMD_SYNC: state_next = l4pbom_pkg::ST_SYNC_WALK;
            l4pbom_pkg::CMD_ENC:  state_next = l4pbom_pkg::ST_ENC_WALK;
          endcase
        end
      end
      l4pbom_pkg::ST_UPDATE: begin
        state_next = l4pbom_pkg::ST_IDLE;
      end
      l4pbom_pkg::ST_SYNC_WALK: begin
        if (!st.map_flagged) begin
          if (st.map_last) state_next = l4pbom_pkg::ST_SUMMARY;
        end else if (st.out_free && st.idx_last && st.map_last) begin
          state_next = l4pbom_pkg::ST_SUMMARY;
        end
      end
      l4pbom_pkg::ST_SUMMARY: begin
        if (st.out_free) state_next = l4pbom_pkg::ST_IDLE;
      end
      l4pbom_pkg::ST_ENC_WALK: begin
        if (st.out_free && st.idx_last && st.map_last) state_next = l4pbom_pkg::ST_IDLE;
      end
      default: state_next = l4pbom_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl.clear_step = 1'b0;
    ctl.load_item  = 1'b0;
    ctl.upd_write  = 1'b0;
    ctl.ptr_op     = l4pbom_pkg::PTR_HOLD;
    ctl.emit       = l4pbom_pkg::EMIT_NONE;
    unique case (state)
      l4pbom_pkg::ST_CLEAR: begin
        ctl.clear_step = 1'b1;
      end
      l4pbom_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.load_item = in_valid;
      end
      l4pbom_pkg::ST_UPDATE: begin
        ctl.upd_write = 1'b1;
      end
      l4pbom_pkg::ST_SYNC_WALK: begin
        // Maps that have not changed are stepped over without a result.
        if (!st.map_flagged) begin
          if (!st.map_last) ctl.ptr_op = l4pbom_pkg::PTR_NEXT_MAP;
        end else if (st.out_free) begin
          ctl.emit   = l4pbom_pkg::EMIT_SYNC_WORD;
          ctl.ptr_op = l4pbom_pkg::PTR_INC;
        end
      end
      l4pbom_pkg::ST_SUMMARY: begin
        if (st.out_free) ctl.emit = l4pbom_pkg::EMIT_SUMMARY;
      end
      l4pbom_pkg::ST_ENC_WALK: begin
        if (st.out_free) begin
          ctl.emit   = l4pbom_pkg::EMIT_ENC_WORD;
          ctl.ptr_op = l4pbom_pkg::PTR_INC;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/l4pbom_dpath.sv =====
// Datapath for the occupancy maps: count RAMs, current and reported bitmaps,
// word pointer and output register. Depends on l4pbom_pkg for widths and command types.
module l4pbom_dpath #(
  parameter int COUNT_WIDTH = l4pbom_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  l4pbom_pkg::ctrl_t          ctl,
  output l4pbom_pkg::stat_t          st,
  input  logic [7:0]                 proto,
  input  logic [1:0]                 cmd,
  input  logic [l4pbom_pkg::PORT_W-1:0] src_port,
  input  logic [l4pbom_pkg::PORT_W-1:0] dst_port,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 map_select,
  output logic [2:0]                 word_index,
  output logic [31:0]                map_word,
  output logic                       is_summary,
  output logic                       any_changed,
  output logic                       last
);

  localparam int BW  = l4pbom_pkg::BUCKET_W;
  localparam int AW  = l4pbom_pkg::BANK_AW;
  localparam int PW  = l4pbom_pkg::PTR_W;
  localparam int MW  = l4pbom_pkg::MAP_W;
  localparam int IW  = l4pbom_pkg::WORD_IDX_W;
  localparam int SW  = l4pbom_pkg::BIT_SEL_W;
  localparam int NM  = l4pbom_pkg::NUM_MAPS;
  localparam int MWD = l4pbom_pkg::MAP_WORDS;
  localparam int BPW = l4pbom_pkg::BITS_PER_WORD;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Count RAMs: one bank for the source maps, one for the destination maps.
  logic [COUNT_WIDTH-1:0] mem_src [l4pbom_pkg::BANK_DEPTH];
  logic [COUNT_WIDTH-1:0] mem_dst [l4pbom_pkg::BANK_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_src, rd_dst;

  logic [BPW-1:0] cur [l4pbom_pkg::NUM_WORDS];
  logic [BPW-1:0] rep [l4pbom_pkg::NUM_WORDS];

  logic [AW-1:0] clr_cnt;
  logic [PW-1:0] ptr;
  logic [NM-1:0] flags, flags_now;
  logic          any_flag;

  // Held item
  logic          item_add, item_ok, item_udp;
  logic [BW-1:0] item_sb, item_db;

  logic [BW-1:0] in_sb, in_db;
  logic          in_udp;

  assign in_udp = (proto == l4pbom_pkg::PROTO_UDP);
  assign in_sb  = BW'(src_port >> l4pbom_pkg::BUCKET_SHIFT);
  assign in_db  = BW'(dst_port >> l4pbom_pkg::BUCKET_SHIFT);

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_add <= (l4pbom_pkg::cmd_t'(cmd) == l4pbom_pkg::CMD_ADD);
      item_ok  <= (proto == l4pbom_pkg::PROTO_TCP) || in_udp;
      item_udp <= in_udp;
      item_sb  <= in_sb;
      item_db  <= in_db;
    end
  end

  // Read-modify-write of both counts in the cycle after the read.
  logic                   src_we, dst_we, src_bit_we, dst_bit_we;
  logic [COUNT_WIDTH-1:0] src_new, dst_new;
  logic [PW-1:0]          src_w, dst_w;

  always_comb begin
    src_new    = item_add ? rd_src + 1'b1 : rd_src - 1'b1;
    dst_new    = item_add ? rd_dst + 1'b1 : rd_dst - 1'b1;
    src_we     = ctl.upd_write && item_ok &&
                 (item_add ? (rd_src != COUNT_MAX) : (rd_src != '0));
    dst_we     = ctl.upd_write && item_ok &&
                 (item_add ? (rd_dst != COUNT_MAX) : (rd_dst != '0));
    src_bit_we = src_we && (item_add ? (rd_src == '0) : (rd_src == COUNT_WIDTH'(1)));
    dst_bit_we = dst_we && (item_add ? (rd_dst == '0) : (rd_dst == COUNT_WIDTH'(1)));
    src_w      = {item_udp, 1'b0, item_sb[BW-1:SW]};
    dst_w      = {item_udp, 1'b1, item_db[BW-1:SW]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_step) begin
      mem_src[clr_cnt] <= '0;
    end else if (src_we) begin
      mem_src[{item_udp, item_sb}] <= src_new;
    end
    if (ctl.load_item) begin
      rd_src <= mem_src[{in_udp, in_sb}];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_step) begin
      mem_dst[clr_cnt] <= '0;
    end else if (dst_we) begin
      mem_dst[{item_udp, item_db}] <= dst_new;
    end
    if (ctl.load_item) begin
      rd_dst <= mem_dst[{in_udp, in_db}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < l4pbom_pkg::NUM_WORDS; w++) begin
        cur[w] <= '0;
        rep[w] <= '0;
      end
    end else begin
      if (src_bit_we) cur[src_w][item_sb[SW-1:0]] <= item_add;
      if (dst_bit_we) cur[dst_w][item_db[SW-1:0]] <= item_add;
      if (ctl.emit == l4pbom_pkg::EMIT_SYNC_WORD) rep[ptr] <= cur[ptr];
    end
  end

  // A map is flagged when any of its words differs from the reported copy.
  always_comb begin
    for (int m = 0; m < NM; m++) begin
      flags_now[m] = 1'b0;
      for (int i = 0; i < MWD; i++) begin
        flags_now[m] = flags_now[m] || (cur[m * MWD + i] != rep[m * MWD + i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      flags    <= '0;
      any_flag <= 1'b0;
    end else if (ctl.load_item) begin
      ptr      <= '0;
      flags    <= flags_now;
      any_flag <= |flags_now;
    end else begin
      case (ctl.ptr_op)
        l4pbom_pkg::PTR_INC:      ptr <= ptr + 1'b1;
        l4pbom_pkg::PTR_NEXT_MAP: ptr <= {ptr[PW-1:IW] + 1'b1, {IW{1'b0}}};
        default:                  ptr <= ptr;
      endcase
    end
  end

  logic map_last_i, idx_last_i;
  assign map_last_i = (ptr[PW-1:IW] == MW'(NM - 1));
  assign idx_last_i = (ptr[IW-1:0] == IW'(MWD - 1));

  always_comb begin
    st.clear_done  = (clr_cnt == AW'(l4pbom_pkg::BANK_DEPTH - 1));
    st.map_flagged = flags[ptr[PW-1:IW]];
    st.map_last    = map_last_i;
    st.idx_last    = idx_last_i;
    st.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit != l4pbom_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.emit)
      l4pbom_pkg::EMIT_SYNC_WORD, l4pbom_pkg::EMIT_ENC_WORD: begin
        map_select  <= ptr[PW-1:IW];
        word_index  <= ptr[IW-1:0];
        map_word    <= cur[ptr];
        is_summary  <= 1'b0;
        any_changed <= 1'b0;
        last        <= (ctl.emit == l4pbom_pkg::EMIT_ENC_WORD) && map_last_i && idx_last_i;
      end
      l4pbom_pkg::EMIT_SUMMARY: begin
        map_select  <= '0;
        word_index  <= '0;
        map_word    <= '0;
        is_summary  <= 1'b1;
        any_changed <= any_flag;
        last        <= 1'b1;
      end
      default: begin
        map_select <= map_select;
      end
    endcase
  end

endmodule

// ===== hdl/l4_port_bucket_occupancy_map.sv =====
// Top level of the layer-4 port bucket occupancy maps: controller and datapath.
// Depends on l4pbom_pkg, l4pbom_ctrl and l4pbom_dpath.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   cmd, proto, src_port, dst_port
//   out      output     out_valid / out_ready map_select, word_index, map_word,
//                                             is_summary, any_changed, last
//
// An add or delete reads the count RAMs at acceptance through their single
// registered read port and writes them back in the next cycle. A sync emits
// each changed map's words, then a summary; an encode emits all 32 words. One
// result leaves per cycle while out_ready is high, but unchanged maps are
// skipped without one. A clearing pass after reset zeroes the count RAMs;
// in_ready stays low meanwhile. A low out_ready holds the walk where it is.
module l4_port_bucket_occupancy_map #(
  parameter int COUNT_WIDTH = l4pbom_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  proto,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  map_select,
  output logic [2:0]  word_index,
  output logic [31:0] map_word,
  output logic        is_summary,
  output logic        any_changed,
  output logic        last
);

  l4pbom_pkg::ctrl_t ctl;
  l4pbom_pkg::stat_t st;

  l4pbom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  l4pbom_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .st          (st),
    .proto       (proto),
    .cmd         (cmd),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .map_select  (map_select),
    .word_index  (word_index),
    .map_word    (map_word),
    .is_summary  (is_summary),
    .any_changed (any_changed),
    .last        (last)
  );

`ifndef SYNTHESIS
  // No transaction is taken while the count RAMs are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_step |-> !in_ready)
    else $error("input accepted during the clearing pass");

  // Adds and deletes need their write-back cycle before the next transaction.
  a_update_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd == l4pbom_pkg::CMD_ADD || cmd == l4pbom_pkg::CMD_DEL))
    |=> !in_ready)
    else $error("input accepted during a count update");

  // The sync summary always closes its run.
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_summary) |-> (last && map_word == '0))
    else $error("summary result without last or with a word");
`endif

endmodule

// ===== verif/occ_check_pkg.sv =====
// Scoreboard for the layer-4 port bucket occupancy maps: the expected-word predictor and checker.
// Depends on l4pbom_pkg for widths, protocol numbers and command codes.
`timescale 1ns / 100ps
package occ_check_pkg;

  // A narrow count lets the saturation case be reached with a handful of adds.
  localparam int COUNT_W = 4;

  localparam int MAP_TCP_SRC = 0;
  localparam int MAP_TCP_DST = 1;
  localparam int MAP_UDP_SRC = 2;
  localparam int MAP_UDP_DST = 3;

  typedef struct packed {
    logic [1:0]  map_select;
    logic [2:0]  word_index;
    logic [31:0] map_word;
    logic        is_summary;
    logic        any_changed;
    logic        last;
  } occ_result_t;

  class occupancy_scoreboard;
    logic [COUNT_W-1:0] ref_counts [l4pbom_pkg::NUM_MAPS][l4pbom_pkg::BUCKETS_PER_MAP];
    logic [31:0]        live_words [l4pbom_pkg::NUM_MAPS][l4pbom_pkg::MAP_WORDS];
    logic [31:0]        sent_words [l4pbom_pkg::NUM_MAPS][l4pbom_pkg::MAP_WORDS];
    occ_result_t        due_words[$];
    int                 errors;

    function new();
      errors = 0;
      for (int m = 0; m < l4pbom_pkg::NUM_MAPS; m++) begin
        for (int b = 0; b < l4pbom_pkg::BUCKETS_PER_MAP; b++) ref_counts[m][b] = '0;
        for (int i = 0; i < l4pbom_pkg::MAP_WORDS; i++) begin
          live_words[m][i] = '0;
          sent_words[m][i] = '0;
        end
      end
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function void queue_result(occ_result_t r);
      due_words = {due_words, r};
    endfunction

    function void bump_bucket(int m, logic [15:0] port, bit add);
      int unsigned bucket;
      int unsigned w;
      int unsigned b;
      bucket = port >> l4pbom_pkg::BUCKET_SHIFT;
      if (bucket >= l4pbom_pkg::BUCKETS_PER_MAP) return;
      w = bucket / l4pbom_pkg::BITS_PER_WORD;
      b = bucket % l4pbom_pkg::BITS_PER_WORD;
      if (add) begin
        // The count sticks at its ceiling rather than wrapping.
        if (ref_counts[m][bucket] == {COUNT_W{1'b1}}) return;
        ref_counts[m][bucket] = ref_counts[m][bucket] + 1'b1;
        if (ref_counts[m][bucket] == 1) live_words[m][w][b] = 1'b1;
      end else begin
        if (ref_counts[m][bucket] == 0) return;
        ref_counts[m][bucket] = ref_counts[m][bucket] - 1'b1;
        if (ref_counts[m][bucket] == 0) live_words[m][w][b] = 1'b0;
      end
    endfunction

    function occ_result_t word_result(int m, int i, logic [31:0] w, bit lst);
      occ_result_t r;
      r.map_select  = 2'(m);
      r.word_index  = 3'(i);
      r.map_word    = w;
      r.is_summary  = 1'b0;
      r.any_changed = 1'b0;
      r.last        = lst;
      return r;
    endfunction

    // Called for every accepted input transaction.
    function void note_command(logic [1:0] c, logic [7:0] p, logic [15:0] s, logic [15:0] d);
      bit          add;
      bit          any_chg;
      bit          chg;
      occ_result_t r;
      case (l4pbom_pkg::cmd_t'(c))
        l4pbom_pkg::CMD_ADD, l4pbom_pkg::CMD_DEL: begin
          add = (l4pbom_pkg::cmd_t'(c) == l4pbom_pkg::CMD_ADD);
          if (p == l4pbom_pkg::PROTO_TCP) begin
            bump_bucket(MAP_TCP_SRC, s, add);
            bump_bucket(MAP_TCP_DST, d, add);
          end else if (p == l4pbom_pkg::PROTO_UDP) begin
            bump_bucket(MAP_UDP_SRC, s, add);
            bump_bucket(MAP_UDP_DST, d, add);
          end
        end
        l4pbom_pkg::CMD_SYNC: begin
          any_chg = 1'b0;
          for (int m = 0; m < l4pbom_pkg::NUM_MAPS; m++) begin
            chg = 1'b0;
            for (int i = 0; i < l4pbom_pkg::MAP_WORDS; i++) begin
              if (live_words[m][i] != sent_words[m][i]) begin
                sent_words[m][i] = live_words[m][i];
                chg = 1'b1;
              end
            end
            if (chg) begin
              any_chg = 1'b1;
              for (int i = 0; i < l4pbom_pkg::MAP_WORDS; i++)
                queue_result(word_result(m, i, sent_words[m][i], 1'b0));
            end
          end
          r = '0;
          r.is_summary  = 1'b1;
          r.any_changed = any_chg;
          r.last        = 1'b1;
          queue_result(r);
        end
        default: begin
          for (int m = 0; m < l4pbom_pkg::NUM_MAPS; m++)
            for (int i = 0; i < l4pbom_pkg::MAP_WORDS; i++)
              queue_result(word_result(m, i, live_words[m][i],
                                       (m == l4pbom_pkg::NUM_MAPS - 1) &&
                                       (i == l4pbom_pkg::MAP_WORDS - 1)));
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_word(occ_result_t act);
      occ_result_t exp_r;
      if (due_words.size() == 0) begin
        $error("result with nothing expected: map %0d word %0d data %0h",
               act.map_select, act.word_index, act.map_word);
        errors++;
        return;
      end
      exp_r = due_words.pop_front();
      check_field("map_select", 32'(exp_r.map_select), 32'(act.map_select));
      check_field("word_index", 32'(exp_r.word_index), 32'(act.word_index));
      check_field("map_word", exp_r.map_word, act.map_word);
      check_field("is_summary", 32'(exp_r.is_summary), 32'(act.is_summary));
      check_field("any_changed", 32'(exp_r.any_changed), 32'(act.any_changed));
      check_field("last", 32'(exp_r.last), 32'(act.last));
    endfunction

    function void flag_leftover();
      if (due_words.size() != 0) begin
        $error("%0d expected results never arrived", due_words.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench for l4_port_bucket_occupancy_map: clock, reset, stimulus and monitors.
// Depends on l4pbom_pkg, occ_check_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 64;
  localparam int HOLD_LEN    = 300;

  typedef struct {
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = '0;
  logic [7:0]  proto = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  map_select;
  logic [2:0]  word_index;
  logic [31:0] map_word;
  logic        is_summary;
  logic        any_changed;
  logic        last;

  occ_check_pkg::occupancy_scoreboard sb;
  flow_t               live_flows[$];
  int                  snd_idle_pct = 0;
  int                  rcv_idle_pct = 0;
  int                  hold_requests = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  cycle_count = 0;

  l4_port_bucket_occupancy_map #(.COUNT_WIDTH(occ_check_pkg::COUNT_W)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .proto(proto), .src_port(src_port), .dst_port(dst_port),
    .out_valid(out_valid), .out_ready(out_ready),
    .map_select(map_select), .word_index(word_index), .map_word(map_word),
    .is_summary(is_summary), .any_changed(any_changed), .last(last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_command(cmd, proto, src_port, dst_port);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word({map_select, word_index, map_word, is_summary, any_changed, last});
  end

  // Within this task valid is only lowered when the sender chooses to idle, so it never
  // drops and rises in the same step.
  task automatic send_item(l4pbom_pkg::cmd_t c, logic [7:0] p, logic [15:0] s,
                           logic [15:0] d);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    proto    <= p;
    src_port <= s;
    dst_port <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // The first edge lets the monitor note the transaction that was just accepted.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_port();
    if ($urandom_range(3) == 0) return 16'($urandom);
    // Most ports land on a coarse grid of buckets so that flows collide.
    return {8'($urandom_range(15) * 17), 8'($urandom)};
  endfunction

  function automatic flow_t make_flow();
    flow_t f;
    if ($urandom_range(9) < 8)
      f.proto = ($urandom_range(1) != 0) ? l4pbom_pkg::PROTO_TCP : l4pbom_pkg::PROTO_UDP;
    else f.proto = 8'($urandom);
    f.sport = pick_port();
    f.dport = pick_port();
    return f;
  endfunction

  task automatic send_random();
    int    pick;
    int    idx;
    flow_t f;
    pick = $urandom_range(99);
    if (pick < 40) begin
      f = make_flow();
      live_flows = {live_flows, f};
      send_item(l4pbom_pkg::CMD_ADD, f.proto, f.sport, f.dport);
    end else if (pick < 70) begin
      // Mostly tear down a flow that exists; now and then a stray delete.
      if (live_flows.size() != 0 && $urandom_range(9) != 0) begin
        idx = $urandom_range(live_flows.size() - 1);
        f = live_flows[idx];
        live_flows.delete(idx);
      end else begin
        f = make_flow();
      end
      send_item(l4pbom_pkg::CMD_DEL, f.proto, f.sport, f.dport);
    end else if (pick < 88) begin
      send_item(l4pbom_pkg::CMD_SYNC, 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_item(l4pbom_pkg::CMD_ENC, 8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int n_items, int s_pct, int r_pct, bit with_hold);
    snd_idle_pct = s_pct;
    rcv_idle_pct = r_pct;
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 2) begin
        // The walks stall behind the held receiver, so the input backs up.
        hold_requests++;
        send_item(l4pbom_pkg::CMD_ENC, 8'd0, 16'd0, 16'd0);
        send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
        send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_UDP, 16'h1357, 16'h2468);
      end
      send_random();
    end
    drain_results();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    snd_idle_pct = 23;
    rcv_idle_pct = 83;
    send_item(l4pbom_pkg::CMD_ENC, 8'd0, 16'd0, 16'd0);
    send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
    send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_TCP, 16'h0000, 16'hFFFF);
    send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_UDP, 16'hFFFF, 16'h0000);
    send_item(l4pbom_pkg::CMD_ADD, 8'd0, 16'h1111, 16'h2222);
    send_item(l4pbom_pkg::CMD_ADD, 8'hFF, 16'h3333, 16'h4444);
    send_item(l4pbom_pkg::CMD_DEL, 8'd7, 16'h0000, 16'hFFFF);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_TCP, 16'h8000, 16'h8000);
    send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
    send_item(l4pbom_pkg::CMD_SYNC, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_TCP, 16'h0001, 16'h00FF);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_TCP, 16'h0000, 16'hFFFF);
    send_item(l4pbom_pkg::CMD_ENC, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_TCP, 16'h00FF, 16'h0080);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_TCP, 16'h00FF, 16'h0080);
    send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
    // A bucket that is set and cleared again between syncs leaves nothing to report.
    send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_UDP, 16'hABCD, 16'h5A5A);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_UDP, 16'hABCD, 16'h5A5A);
    send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
    send_item(l4pbom_pkg::CMD_ENC, 8'd0, 16'd0, 16'd0);
    drain_results();

    // Drive one bucket pair past the count ceiling, then step back once.
    for (int k = 0; k <= (1 << occ_check_pkg::COUNT_W); k++)
      send_item(l4pbom_pkg::CMD_ADD, l4pbom_pkg::PROTO_TCP, 16'h4242, 16'hC342);
    send_item(l4pbom_pkg::CMD_DEL, l4pbom_pkg::PROTO_TCP, 16'h4242, 16'hC342);
    send_item(l4pbom_pkg::CMD_SYNC, 8'd0, 16'd0, 16'd0);
    send_item(l4pbom_pkg::CMD_ENC, 8'd0, 16'd0, 16'd0);
    drain_results();

    random_phase(20, 23, 83, 1'b0);
    random_phase(20, 83, 23, 1'b0);
    random_phase(20, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== l4_port_bucket_occupancy_map.f =====
hdl/l4pbom_pkg.sv
hdl/l4pbom_ctrl.sv
hdl/l4pbom_dpath.sv
hdl/l4_port_bucket_occupancy_map.sv
verif/occ_check_pkg.sv
verif/tb.sv
